### rtl/core/pos_pkg.sv
`default_nettype none

package pos_pkg;

    localparam int CW  = 32;        // coordinate width
    localparam int FB  = 16;        // fraction bits
    localparam int DW  = 18;        // unit direction component, signed
    localparam int AW  = 36;        // multiplier operand A, signed
    localparam int MBW = 32;        // multiplier operand B, signed
    localparam int PW  = AW + MBW;  // product
    localparam int WW  = PW + 2;    // headroom for sums of products
    localparam int SW  = 62;        // square root working width
    localparam int LW  = 31;        // segment length after normalising
    localparam int NMW = 36;        // join numerator, signed
    localparam int DNW = 20;        // join denominator, signed
    localparam int QB  = 34;        // quotient bits of the divider
    localparam int BW  = QB + 1;    // signed miter distance
    localparam int DVW = 64;        // divider dividend width
    localparam int NORM_HI_BIT = 30;
    localparam int NORM_LO_BIT = 29;
    localparam int SQ_TOP_BIT  = 60;
    localparam int LIM_BIT     = CW + 1;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [DW-1:0] DIR_ONE   = DW'(1) <<< FB;
    localparam logic [QB-1:0]        B_LIM     = QB'(1) << LIM_BIT;

    // datapath operations
    localparam logic [5:0] OP_NOP    = 6'd0;
    localparam logic [5:0] OP_CAP    = 6'd1;
    localparam logic [5:0] OP_ANCHOR = 6'd2;
    localparam logic [5:0] OP_CLEAR  = 6'd3;
    localparam logic [5:0] OP_DIFF   = 6'd4;
    localparam logic [5:0] OP_NORM   = 6'd5;
    localparam logic [5:0] OP_SQA    = 6'd6;
    localparam logic [5:0] OP_SQB    = 6'd7;
    localparam logic [5:0] OP_SQRT   = 6'd8;
    localparam logic [5:0] OP_DVX    = 6'd9;
    localparam logic [5:0] OP_VX     = 6'd10;
    localparam logic [5:0] OP_DVY    = 6'd11;
    localparam logic [5:0] OP_VY     = 6'd12;
    localparam logic [5:0] OP_QXM    = 6'd13;
    localparam logic [5:0] OP_QXA    = 6'd14;
    localparam logic [5:0] OP_QYM    = 6'd15;
    localparam logic [5:0] OP_QYA    = 6'd16;
    localparam logic [5:0] OP_JQ     = 6'd17;
    localparam logic [5:0] OP_J1     = 6'd18;
    localparam logic [5:0] OP_J2     = 6'd19;
    localparam logic [5:0] OP_J3     = 6'd20;
    localparam logic [5:0] OP_J4     = 6'd21;
    localparam logic [5:0] OP_J5     = 6'd22;
    localparam logic [5:0] OP_J6     = 6'd23;
    localparam logic [5:0] OP_DVJ    = 6'd24;
    localparam logic [5:0] OP_JB     = 6'd25;
    localparam logic [5:0] OP_JXM    = 6'd26;
    localparam logic [5:0] OP_JXA    = 6'd27;
    localparam logic [5:0] OP_JYM    = 6'd28;
    localparam logic [5:0] OP_JYA    = 6'd29;
    localparam logic [5:0] OP_EMIT1  = 6'd30;
    localparam logic [5:0] OP_EXM    = 6'd31;
    localparam logic [5:0] OP_EXA    = 6'd32;
    localparam logic [5:0] OP_EYM    = 6'd33;
    localparam logic [5:0] OP_EYA    = 6'd34;
    localparam logic [5:0] OP_EMIT2  = 6'd35;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 last_point;
    } t_in_word;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic                 out_last;
    } t_out_word;

    typedef struct packed {
        logic [5:0] op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic same_pt;
        logic norm_ok;
        logic sqrt_done;
        logic div_busy;
        logic den_zero;
        logic out_free;
    } t_sts;

    // shift right by FB, rounding half away from zero
    function automatic logic signed [WW-1:0] rnd_fb(input logic signed [WW-1:0] v);
        logic [WW-1:0] m;
        begin
            m = v[WW-1] ? WW'(-v) : WW'(v);
            m = (m + (WW'(1) << (FB - 1))) >> FB;
            rnd_fb = v[WW-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [WW-1:0] v);
        begin
            if (v > WW'(COORD_MAX)) begin
                sat_cw = COORD_MAX;
            end else if (v < WW'(COORD_MIN)) begin
                sat_cw = COORD_MIN;
            end else begin
                sat_cw = v[CW-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/pos_div.sv
`default_nettype none

module pos_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [pos_pkg::DVW-1:0] i_num,
    input  logic [pos_pkg::LW-1:0]  i_den,
    output logic                    o_busy,
    output logic [pos_pkg::QB-1:0]  o_quo,
    output logic                    o_ovf
);
    import pos_pkg::*;

    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dsh;
    logic [QB-1:0]  r_quo;
    logic [5:0]     r_cnt;
    logic           r_ovf;
    logic           ovf_now;

    // quotient would not fit in QB bits
    assign ovf_now = {{(QB + LW - DVW){1'b0}}, i_num} >= {i_den, {QB{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'(QB);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, {(QB - 1){1'b0}}};
            r_quo <= '0;
            r_ovf <= ovf_now;
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QB-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QB-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

### rtl/core/pos_dp.sv
`default_nettype none

module pos_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_data,
    input  pos_pkg::t_in_word   i_in,
    input  pos_pkg::t_cmd       i_cmd,
    input  logic                i_out_ready,
    output pos_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output pos_pkg::t_out_word  o_out
);
    import pos_pkg::*;

    logic signed [CW-1:0]  r_off;
    logic signed [CW-1:0]  r_px, r_py, r_anc_x, r_anc_y, r_prev_x, r_prev_y;
    logic                  r_last;
    logic signed [DW-1:0]  r_dir_x, r_dir_y, r_vx, r_vy;
    logic [CW-1:0]         r_ax, r_ay;
    logic                  r_sx, r_sy;
    logic signed [PW-1:0]  r_acc, r_prod;
    logic [SW-1:0]         r_sv, r_res, r_bit;
    logic signed [CW-1:0]  r_qx, r_qy, r_jx, r_jy;
    logic signed [NMW-1:0] r_num;
    logic signed [DNW-1:0] r_den;
    logic signed [BW-1:0]  r_b;
    logic                  r_ov;
    t_out_word             r_out;

    logic signed [AW-1:0]  mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [CW:0]    dx, dy, w_x, w_y;
    logic [CW-1:0]         m;
    logic signed [WW-1:0]  rnd_p, rnd_d;
    logic [SW-1:0]         sq_t;
    logic [LW-1:0]         len;
    logic [NMW-1:0]        num_mag;
    logic [DNW-1:0]        den_mag;
    logic                  div_start, div_busy, div_ovf;
    logic [DVW-1:0]        div_num;
    logic [LW-1:0]         div_den;
    logic [QB-1:0]         div_quo, bm;
    logic signed [DW-1:0]  q_dir;
    logic                  out_free;

    assign mul_p = mul_a * mul_b;
    assign dx    = {r_px[CW-1], r_px} - {r_anc_x[CW-1], r_anc_x};
    assign dy    = {r_py[CW-1], r_py} - {r_anc_y[CW-1], r_anc_y};
    assign w_x   = {r_prev_x[CW-1], r_prev_x} - {r_qx[CW-1], r_qx};
    assign w_y   = {r_prev_y[CW-1], r_prev_y} - {r_qy[CW-1], r_qy};
    assign m     = (r_ax > r_ay) ? r_ax : r_ay;
    assign rnd_p = rnd_fb(WW'(r_prod));
    assign rnd_d = rnd_fb(WW'(r_acc) - WW'(r_prod));
    assign sq_t  = r_res + r_bit;
    assign len   = r_res[LW-1:0];
    assign num_mag = r_num[NMW-1] ? NMW'(-r_num) : NMW'(r_num);
    assign den_mag = r_den[DNW-1] ? DNW'(-r_den) : DNW'(r_den);
    assign q_dir   = $signed(div_quo[DW-1:0]);
    assign bm      = (div_ovf || div_quo > B_LIM) ? B_LIM : div_quo;
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQA: begin
                mul_a = $signed(AW'(r_ax));
                mul_b = $signed(r_ax);
            end
            OP_SQB: begin
                mul_a = $signed(AW'(r_ay));
                mul_b = $signed(r_ay);
            end
            OP_QXM: begin
                mul_a = AW'(r_off);
                mul_b = -MBW'(r_vy);
            end
            OP_QYM: begin
                mul_a = AW'(r_off);
                mul_b = MBW'(r_vx);
            end
            OP_J1: begin
                mul_a = AW'(w_x);
                mul_b = MBW'(r_dir_y);
            end
            OP_J2: begin
                mul_a = AW'(w_y);
                mul_b = MBW'(r_dir_x);
            end
            OP_J4: begin
                mul_a = AW'(r_vx);
                mul_b = MBW'(r_dir_y);
            end
            OP_J5: begin
                mul_a = AW'(r_vy);
                mul_b = MBW'(r_dir_x);
            end
            OP_JXM: begin
                mul_a = AW'(r_b);
                mul_b = MBW'(r_vx);
            end
            OP_JYM: begin
                mul_a = AW'(r_b);
                mul_b = MBW'(r_vy);
            end
            OP_EXM: begin
                mul_a = AW'(r_off);
                mul_b = -MBW'(r_dir_y);
            end
            OP_EYM: begin
                mul_a = AW'(r_off);
                mul_b = MBW'(r_dir_x);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (i_cmd.op)
            OP_DVX: begin
                div_start = 1'b1;
                div_num   = (DVW'(r_ax) << FB) + DVW'(len >> 1);
                div_den   = len;
            end
            OP_DVY: begin
                div_start = 1'b1;
                div_num   = (DVW'(r_ay) << FB) + DVW'(len >> 1);
                div_den   = len;
            end
            OP_DVJ: begin
                div_start = 1'b1;
                div_num   = (DVW'(num_mag) << FB) + DVW'(den_mag >> 1);
                div_den   = LW'(den_mag);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

    // offset register and direction carry reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_dir_x <= DIR_ONE;
            r_dir_y <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_off <= $signed(i_cfg_data);
            end
            if (i_cmd.op == OP_EMIT1) begin
                r_dir_x <= r_vx;
                r_dir_y <= r_vy;
            end else if (i_cmd.op == OP_EMIT2 || i_cmd.op == OP_CLEAR) begin
                r_dir_x <= DIR_ONE;
                r_dir_y <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_EMIT1 || i_cmd.op == OP_EMIT2) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_px   <= i_in.point_x;
                r_py   <= i_in.point_y;
                r_last <= i_in.last_point;
            end
            OP_ANCHOR: begin
                r_anc_x <= r_px;
                r_anc_y <= r_py;
            end
            OP_DIFF: begin
                r_sx <= dx[CW];
                r_sy <= dy[CW];
                r_ax <= dx[CW] ? CW'(-dx) : CW'(dx);
                r_ay <= dy[CW] ? CW'(-dy) : CW'(dy);
            end
            OP_NORM: begin
                if (|m[CW-1:NORM_HI_BIT]) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            OP_SQA: r_acc <= mul_p;
            OP_SQB: begin
                r_sv  <= SW'(r_acc + mul_p);
                r_res <= '0;
                r_bit <= SW'(1) << SQ_TOP_BIT;
            end
            OP_SQRT: begin
                if (r_sv >= sq_t) begin
                    r_sv  <= r_sv - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_VX:  r_vx <= r_sx ? -q_dir : q_dir;
            OP_VY:  r_vy <= r_sy ? -q_dir : q_dir;
            OP_QXM: r_prod <= mul_p;
            OP_QXA: r_qx <= sat_cw(WW'(r_anc_x) + rnd_p);
            OP_QYM: r_prod <= mul_p;
            OP_QYA: r_qy <= sat_cw(WW'(r_anc_y) + rnd_p);
            OP_JQ: begin
                r_jx <= r_qx;
                r_jy <= r_qy;
            end
            OP_J1:  r_acc <= mul_p;
            OP_J2:  r_prod <= mul_p;
            OP_J3:  r_num <= rnd_d[NMW-1:0];
            OP_J4:  r_acc <= mul_p;
            OP_J5:  r_prod <= mul_p;
            OP_J6:  r_den <= rnd_d[DNW-1:0];
            OP_JB: begin
                if (r_num[NMW-1] != r_den[DNW-1]) begin
                    r_b <= -$signed({1'b0, bm});
                end else begin
                    r_b <= $signed({1'b0, bm});
                end
            end
            OP_JXM: r_prod <= mul_p;
            OP_JXA: r_jx <= sat_cw(WW'(r_qx) + rnd_p);
            OP_JYM: r_prod <= mul_p;
            OP_JYA: r_jy <= sat_cw(WW'(r_qy) + rnd_p);
            OP_EMIT1: begin
                r_out.out_x    <= r_jx;
                r_out.out_y    <= r_jy;
                r_out.out_last <= 1'b0;
                r_prev_x       <= r_jx;
                r_prev_y       <= r_jy;
                r_anc_x        <= r_px;
                r_anc_y        <= r_py;
            end
            OP_EXM: r_prod <= mul_p;
            OP_EXA: r_jx <= sat_cw(WW'(r_px) + rnd_p);
            OP_EYM: r_prod <= mul_p;
            OP_EYA: r_jy <= sat_cw(WW'(r_py) + rnd_p);
            OP_EMIT2: begin
                r_out.out_x    <= r_jx;
                r_out.out_y    <= r_jy;
                r_out.out_last <= 1'b1;
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    assign o_sts.last      = r_last;
    assign o_sts.same_pt   = (r_px == r_anc_x) && (r_py == r_anc_y);
    assign o_sts.norm_ok   = !(|m[CW-1:NORM_HI_BIT]) && m[NORM_LO_BIT];
    assign o_sts.sqrt_done = (r_bit == '0);
    assign o_sts.div_busy  = div_busy;
    assign o_sts.den_zero  = (r_den == '0);
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_ov;
    assign o_out           = r_out;

endmodule

`default_nettype wire

### rtl/core/pos_ctrl.sv
`default_nettype none

module pos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pos_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output pos_pkg::t_cmd o_cmd
);
    import pos_pkg::*;

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_CHK  = 6'd1;
    localparam logic [5:0] S_DIFF = 6'd2;
    localparam logic [5:0] S_NORM = 6'd3;
    localparam logic [5:0] S_SQA  = 6'd4;
    localparam logic [5:0] S_SQB  = 6'd5;
    localparam logic [5:0] S_SQRT = 6'd6;
    localparam logic [5:0] S_DVXS = 6'd7;
    localparam logic [5:0] S_DVXW = 6'd8;
    localparam logic [5:0] S_DVYS = 6'd9;
    localparam logic [5:0] S_DVYW = 6'd10;
    localparam logic [5:0] S_QXM  = 6'd11;
    localparam logic [5:0] S_QXA  = 6'd12;
    localparam logic [5:0] S_QYM  = 6'd13;
    localparam logic [5:0] S_QYA  = 6'd14;
    localparam logic [5:0] S_JQ   = 6'd15;
    localparam logic [5:0] S_J1   = 6'd16;
    localparam logic [5:0] S_J2   = 6'd17;
    localparam logic [5:0] S_J3   = 6'd18;
    localparam logic [5:0] S_J4   = 6'd19;
    localparam logic [5:0] S_J5   = 6'd20;
    localparam logic [5:0] S_J6   = 6'd21;
    localparam logic [5:0] S_JZ   = 6'd22;
    localparam logic [5:0] S_JW   = 6'd23;
    localparam logic [5:0] S_JXM  = 6'd24;
    localparam logic [5:0] S_JXA  = 6'd25;
    localparam logic [5:0] S_JYM  = 6'd26;
    localparam logic [5:0] S_JYA  = 6'd27;
    localparam logic [5:0] S_EM1  = 6'd28;
    localparam logic [5:0] S_EXM  = 6'd29;
    localparam logic [5:0] S_EXA  = 6'd30;
    localparam logic [5:0] S_EYM  = 6'd31;
    localparam logic [5:0] S_EYA  = 6'd32;
    localparam logic [5:0] S_EM2  = 6'd33;

    logic [5:0] r_state, n_state;
    logic       r_has_anchor, n_has_anchor;
    logic       r_has_seg, n_has_seg;
    logic [5:0] op;

    always_comb begin
        n_state      = r_state;
        n_has_anchor = r_has_anchor;
        n_has_seg    = r_has_seg;
        op           = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_CAP;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!r_has_anchor) begin
                    n_state = S_IDLE;
                    if (i_sts.last) begin
                        op = OP_CLEAR;
                    end else begin
                        op           = OP_ANCHOR;
                        n_has_anchor = 1'b1;
                    end
                end else if (!i_sts.same_pt) begin
                    n_state = S_DIFF;
                end else if (i_sts.last) begin
                    n_state = S_EXM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                op      = OP_DIFF;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_ok) begin
                    n_state = S_SQA;
                end else begin
                    op = OP_NORM;
                end
            end
            S_SQA: begin
                op      = OP_SQA;
                n_state = S_SQB;
            end
            S_SQB: begin
                op      = OP_SQB;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_DVXS;
                end else begin
                    op = OP_SQRT;
                end
            end
            S_DVXS: begin
                op      = OP_DVX;
                n_state = S_DVXW;
            end
            S_DVXW: begin
                if (!i_sts.div_busy) begin
                    op      = OP_VX;
                    n_state = S_DVYS;
                end
            end
            S_DVYS: begin
                op      = OP_DVY;
                n_state = S_DVYW;
            end
            S_DVYW: begin
                if (!i_sts.div_busy) begin
                    op      = OP_VY;
                    n_state = S_QXM;
                end
            end
            S_QXM: begin
                op      = OP_QXM;
                n_state = S_QXA;
            end
            S_QXA: begin
                op      = OP_QXA;
                n_state = S_QYM;
            end
            S_QYM: begin
                op      = OP_QYM;
                n_state = S_QYA;
            end
            S_QYA: begin
                op      = OP_QYA;
                n_state = r_has_seg ? S_J1 : S_JQ;
            end
            S_JQ: begin
                op      = OP_JQ;
                n_state = S_EM1;
            end
            S_J1: begin
                op      = OP_J1;
                n_state = S_J2;
            end
            S_J2: begin
                op      = OP_J2;
                n_state = S_J3;
            end
            S_J3: begin
                op      = OP_J3;
                n_state = S_J4;
            end
            S_J4: begin
                op      = OP_J4;
                n_state = S_J5;
            end
            S_J5: begin
                op      = OP_J5;
                n_state = S_J6;
            end
            S_J6: begin
                op      = OP_J6;
                n_state = S_JZ;
            end
            S_JZ: begin
                if (i_sts.den_zero) begin
                    op      = OP_JQ;
                    n_state = S_EM1;
                end else begin
                    op      = OP_DVJ;
                    n_state = S_JW;
                end
            end
            S_JW: begin
                if (!i_sts.div_busy) begin
                    op      = OP_JB;
                    n_state = S_JXM;
                end
            end
            S_JXM: begin
                op      = OP_JXM;
                n_state = S_JXA;
            end
            S_JXA: begin
                op      = OP_JXA;
                n_state = S_JYM;
            end
            S_JYM: begin
                op      = OP_JYM;
                n_state = S_JYA;
            end
            S_JYA: begin
                op      = OP_JYA;
                n_state = S_EM1;
            end
            S_EM1: begin
                if (i_sts.out_free) begin
                    op        = OP_EMIT1;
                    n_has_seg = 1'b1;
                    n_state   = i_sts.last ? S_EXM : S_IDLE;
                end
            end
            S_EXM: begin
                op      = OP_EXM;
                n_state = S_EXA;
            end
            S_EXA: begin
                op      = OP_EXA;
                n_state = S_EYM;
            end
            S_EYM: begin
                op      = OP_EYM;
                n_state = S_EYA;
            end
            S_EYA: begin
                op      = OP_EYA;
                n_state = S_EM2;
            end
            S_EM2: begin
                if (i_sts.out_free) begin
                    op           = OP_EMIT2;
                    n_has_anchor = 1'b0;
                    n_has_seg    = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_has_anchor <= 1'b0;
            r_has_seg    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_has_anchor <= n_has_anchor;
            r_has_seg    <= n_has_seg;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = op;

endmodule

`default_nettype wire

### rtl/core/polyline_offset_stream_unit.sv
`default_nettype none

// Polyline offset with miter joins.
// Input channel (i_in_valid / o_in_ready / i_in): one vertex word per
// handshake, signed Q16.16 x and y plus a last-vertex flag.
// Output channel (o_out_valid / i_out_ready / o_out): offset vertex words;
// out_last marks the offset end point of a polyline.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): offset distance,
// Q16.16, positive to the left of travel. Always ready; write it only while
// the block is idle.
// Sequencing: one vertex at a time. A new segment runs the normalising shifter,
// the bit-serial square root and two runs of the shared restoring divider;
// a miter join adds one more divide unless its lines are parallel, and a
// last vertex adds the end point.
// A result sits in a single output register; if the receiver stalls, the
// sequencer holds in its emit step until that register frees, and no new
// word is taken meanwhile.
// Reset (i_rst_n low, synchronous) clears the offset to zero, drops any
// partial polyline and empties the output register.

module polyline_offset_stream_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pos_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pos_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import pos_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: walks the per-vertex steps
    pos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // arithmetic, polyline state and output register
    pos_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
    import pos_pkg::*;

    // Bench for the polyline offset unit. Vertex words go in over a valid/ready
    // channel, offset vertex words come back over another. A behavioural copy of
    // the offset and miter-join arithmetic predicts every result word; the
    // checker compares each accepted result word with the oldest prediction.

    localparam int CLK_HALF  = 4;
    localparam int RST_CYC   = 7;
    localparam int IDLE_LIM  = 20000;   // cycles with no handshake before giving up
    localparam int SETTLE    = 400;     // longer than the slowest segment + join + end

    localparam logic [63:0] N_LO = 64'd1 << 29;
    localparam logic [63:0] N_HI = 64'd1 << 30;
    localparam longint      C_MAX = 64'sd2147483647;
    localparam longint      C_MIN = -64'sd2147483648;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    polyline_offset_stream_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Offset predictor: own copy of the polyline state and the distance
    // ---------------------------------------------------------------------
    longint    dist_q;
    longint    pt_ax, pt_ay, jn_px, jn_py, ud_x, ud_y;
    bit        got_anchor, got_seg;
    t_out_word offset_words_q[$];

    int errors      = 0;
    int words_in    = 0;
    int words_out   = 0;
    int joins_seen  = 0;
    int polylines   = 0;
    int idle_cycles = 0;

    // idling controls
    bit     quiet_mode = 1'b0;   // no random idling on either side
    bit     hold_sink  = 1'b0;   // receiver held off
    int     hold_len   = 0;

    function automatic logic [63:0] mag64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(logic [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // shift right by FB, rounding half away from zero
    function automatic longint round_fb(longint v);
        logic [63:0] m;
        m = (mag64(v) + (64'd1 << (FB - 1))) >> FB;
        return signed_of(m, v < 0);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    task automatic unit_vector(input longint dx, input longint dy,
                               output longint ux, output longint uy);
        logic [63:0] ax, ay, m, len;
        ax = mag64(dx);
        ay = mag64(dy);
        m = ax > ay ? ax : ay;
        while (m >= N_HI) begin ax >>= 1; ay >>= 1; m >>= 1; end
        while (m < N_LO) begin ax <<= 1; ay <<= 1; m <<= 1; end
        len = floor_sqrt(ax * ax + ay * ay);
        ux = signed_of(((ax << FB) + len / 2) / len, dx < 0);
        uy = signed_of(((ay << FB) + len / 2) / len, dy < 0);
    endtask

    task automatic shift_point(input longint px, input longint py, input longint ux,
                               input longint uy, output longint ox, output longint oy);
        ox = clamp_coord(px + round_fb(-uy * dist_q));
        oy = clamp_coord(py + round_fb(ux * dist_q));
    endtask

    // intersection of the previous offset line with the new one
    task automatic miter_point(input longint qx, input longint qy, input longint vx,
                               input longint vy, output longint ox, output longint oy);
        longint      wx, wy, num, den, b;
        logic [63:0] an, ad, q0, r, bm, lim;
        lim = 64'd1 << (CW + 1);
        wx = jn_px - qx;
        wy = jn_py - qy;
        num = round_fb(wx * ud_y - wy * ud_x);
        den = round_fb(vx * ud_y - vy * ud_x);
        if (den == 0) begin
            // parallel or reversed: new segment's own start point
            ox = qx;
            oy = qy;
        end else begin
            an = mag64(num);
            ad = mag64(den);
            q0 = an / ad;
            r = an % ad;
            if (q0 >= (lim >> FB)) begin
                bm = lim;
            end else begin
                bm = (q0 << FB) + ((r << FB) + ad / 2) / ad;
                if (bm > lim) bm = lim;
            end
            b = signed_of(bm, (num < 0) != (den < 0));
            ox = clamp_coord(qx + round_fb(vx * b));
            oy = clamp_coord(qy + round_fb(vy * b));
        end
    endtask

    task automatic clear_polyline();
        pt_ax = 0; pt_ay = 0; jn_px = 0; jn_py = 0;
        ud_x = longint'(1) << FB; ud_y = 0;
        got_anchor = 1'b0; got_seg = 1'b0;
    endtask

    function automatic t_out_word make_word(longint x, longint y, bit lst);
        t_out_word w;
        w.out_x = x[CW-1:0];
        w.out_y = y[CW-1:0];
        w.out_last = lst;
        return w;
    endfunction

    task automatic predict_offset(input t_in_word w);
        longint px, py, vx, vy, qx, qy, jx, jy, ex, ey;
        px = longint'(w.point_x);
        py = longint'(w.point_y);
        if (!got_anchor) begin
            pt_ax = px; pt_ay = py; got_anchor = 1'b1;
            if (w.last_point) clear_polyline();
            return;
        end
        if (px != pt_ax || py != pt_ay) begin
            unit_vector(px - pt_ax, py - pt_ay, vx, vy);
            shift_point(pt_ax, pt_ay, vx, vy, qx, qy);
            if (got_seg) begin
                miter_point(qx, qy, vx, vy, jx, jy);
                joins_seen++;
            end else begin
                jx = qx; jy = qy;
            end
            offset_words_q.push_back(make_word(jx, jy, 1'b0));
            jn_px = jx; jn_py = jy; ud_x = vx; ud_y = vy;
            got_seg = 1'b1;
            pt_ax = px; pt_ay = py;
        end
        if (w.last_point) begin
            shift_point(px, py, ud_x, ud_y, ex, ey);
            offset_words_q.push_back(make_word(ex, ey, 1'b1));
            polylines++;
            clear_polyline();
        end
    endtask

    // ---------------------------------------------------------------------
    // Checker and watchdog
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch #%0d at %0t: %s got %0d expected %0d",
                 errors, $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (offset_words_q.size() == 0) begin
                report_mismatch("unexpected word, x", longint'(o_out.out_x), 0);
            end else begin
                want = offset_words_q.pop_front();
                if (o_out.out_x !== want.out_x)
                    report_mismatch("out_x", longint'(o_out.out_x), longint'(want.out_x));
                if (o_out.out_y !== want.out_y)
                    report_mismatch("out_y", longint'(o_out.out_y), longint'(want.out_y));
                if (o_out.out_last !== want.out_last)
                    report_mismatch("out_last", o_out.out_last, want.out_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIM) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIM);
            $display("FAIL polyline_offset_stream_unit");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when asked
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            i_out_ready <= 1'b0;
        end else if (hold_sink) begin
            hold_sink <= 1'b0;
            hold_len <= 600;
            i_out_ready <= 1'b0;
        end else if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 13);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic send_vertex(input longint x, input longint y, input bit lst);
        t_in_word w;
        w.point_x = x[CW-1:0];
        w.point_y = y[CW-1:0];
        w.last_point = lst;
        // the unit is busy after it takes a word, so step past that clock edge,
        // then a random idle before offering the word
        @(posedge i_clk);
        while (!quiet_mode && $urandom_range(99) < 13) @(posedge i_clk);
        i_in <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_offset(w);
        words_in++;
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (offset_words_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // the block must be idle here
    task automatic write_offset(input logic [31:0] d);
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        dist_q = longint'($signed(d));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(5))
            0: return longint'($signed($urandom()));
            1: return longint'($signed($urandom())) >>> 12;
            2: return longint'($urandom_range(7)) - 3;
            3: return $urandom_range(1) ? C_MAX : C_MIN;
            default: return longint'($signed($urandom())) >>> 4;
        endcase
    endfunction

    function automatic logic [31:0] rand_offset();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'(longint'($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(longint'($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    // one polyline of n vertices; repeats are mixed in now and then
    task automatic send_polyline(input int n);
        longint x, y;
        x = rand_coord();
        y = rand_coord();
        for (int k = 0; k < n; k++) begin
            send_vertex(x, y, k == n - 1);
            if ($urandom_range(9) != 0) begin
                if ($urandom_range(3) == 0) begin
                    x = rand_coord(); y = rand_coord();
                end else begin
                    x = clamp_coord(x + (longint'($signed($urandom())) >>> $urandom_range(28, 8)));
                    y = clamp_coord(y + (longint'($signed($urandom())) >>> $urandom_range(28, 8)));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_directed();
        write_offset(32'h0001_0000);
        send_vertex(0, 0, 1'b1);                            // single point
        send_vertex(0, 0, 1'b0); send_vertex(0, 0, 1'b1);   // no valid segment
        send_vertex(0, 0, 1'b0);                            // square corner
        send_vertex(64'sd655360, 0, 1'b0);
        send_vertex(64'sd655360, 64'sd655360, 1'b0);
        send_vertex(64'sd655360, 64'sd655360, 1'b0);        // zero-length skip
        send_vertex(64'sd655360, 64'sd1310720, 1'b0);       // parallel continuation
        send_vertex(64'sd655360, 0, 1'b1);                  // reversed, last
        drain_results();
        write_offset(32'h7fff_ffff);                        // extremes
        send_vertex(C_MIN, C_MIN, 1'b0);
        send_vertex(C_MAX, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b0);
        send_vertex(C_MIN, C_MAX, 1'b1);                    // repeat flagged last
        drain_results();
        write_offset(32'h8000_0000);
        send_vertex(C_MAX, C_MIN, 1'b0);
        send_vertex(-1, -1, 1'b0);
        send_vertex(1, 0, 1'b0);
        send_vertex(C_MAX, 1, 1'b1);
        drain_results();
    endtask

    task automatic test_random(input int target);
        int start_in;
        start_in = words_in;
        while (words_in - start_in < target) begin
            if ($urandom_range(9) == 0) begin
                send_vertex(rand_coord(), rand_coord(), $urandom_range(1));  // noise
            end else begin
                send_polyline($urandom_range(1, 8));
            end
            if ($urandom_range(39) == 0) begin
                drain_results();
                write_offset(rand_offset());
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_sink <= 1'b1;
        @(posedge i_clk);
        send_polyline(12);     // input stalls behind the held output register
        drain_results();
    endtask

    task automatic test_no_idle();
        quiet_mode = 1'b1;
        test_random(250);
        quiet_mode = 1'b0;
    endtask

    initial begin
        dist_q = 0;
        clear_polyline();
        repeat (RST_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(800);
        test_backpressure();
        test_no_idle();
        drain_results();
        write_offset(32'h0000_0000);
        test_random(200);
        write_offset(32'h7fff_ffff);
        test_random(150);
        write_offset(32'h8000_0000);
        test_random(150);
        test_backpressure();

        $display("covered %0d vertex words, %0d polylines, %0d result words, %0d joins",
                 words_in, polylines, words_out, joins_seen);
        $display("offset settings included zero and both extremes; %0d mismatches", errors);
        if (errors == 0 && offset_words_q.size() == 0) begin
            $display("PASS polyline_offset_stream_unit");
        end else begin
            $display("FAIL polyline_offset_stream_unit");
        end
        $finish;
    end

endmodule
